FILE: hdl/spherical_depth_to_points_unit_macros.svh
// Assertion macros shared by the spherical depth to point cloud design
`ifndef SPHERICAL_DEPTH_TO_POINTS_UNIT_MACROS_SVH
`define SPHERICAL_DEPTH_TO_POINTS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SDP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SDP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sdp_pkg.sv
// Shared types and constants of the spherical depth to point cloud design
package sdp_pkg;

    localparam int DEPTH_W     = 16;
    localparam int COLOUR_W    = 8;
    localparam int COORD_W     = 17;
    localparam int CFG_INDEX_W = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 80;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DEPTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DEPTH = 4'd1;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RESET = 16'd400;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 16'd20000;

    typedef struct packed {
        logic                point_valid;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } pix_side_t;

endpackage

FILE: hdl/spherical_depth_to_points_unit.sv
// Spherical depth image to coloured 3D point converter, top level
// Input requests pass the registered sine/cosine read, two multiplier stages and rounding.
// Throughput: one pixel per cycle; the whole pipeline holds while the output register waits.
// Reset clears the column and row counters and the pipeline valid flags, loads the phi
// counter with its start address and sets limits to 400/20000.
// The sine/cosine memory is constant and needs no clearing pass after reset.
`include "spherical_depth_to_points_unit_macros.svh"

module spherical_depth_to_points_unit #(
    parameter int IMAGE_COLS     = 2048,
    parameter int IMAGE_ROWS     = 1024,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // depth_mm[15:0], blue_in[23:16], green_in[31:24], red_in[39:32]
    input  logic [sdp_pkg::S_TDATA_W-1:0]         s_tdata,
    // frame_start[0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // x_mm[16:0], y_mm[33:17], z_mm[50:34], red_out[58:51], green_out[66:59],
    // blue_out[74:67], zero fill[79:75]
    output logic [sdp_pkg::M_TDATA_W-1:0]         m_tdata,
    // point_valid[0]
    output logic                                  m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sdp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [sdp_pkg::DEPTH_W-1:0]           cfg_data
);

    localparam int ADDR_W = $clog2(IMAGE_COLS);
    localparam int TW     = TRIG_FRAC_BITS + 1;
    localparam int DW     = sdp_pkg::DEPTH_W;
    localparam int CW     = sdp_pkg::COORD_W;

    logic [DW-1:0] min_depth_reg, min_depth_next;
    logic [DW-1:0] max_depth_reg, max_depth_next;

    logic                 advance, accept;
    logic [ADDR_W-1:0]    theta_addr, phi_addr;
    logic signed [TW-1:0] sin_theta, cos_theta, sin_phi, cos_phi;
    logic [DW-1:0]        in_depth;
    sdp_pkg::pix_side_t   in_side, out_side;
    logic signed [CW-1:0] x_mm, y_mm, z_mm;

    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        min_depth_next = min_depth_reg;
        max_depth_next = max_depth_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sdp_pkg::CFG_MIN_DEPTH: min_depth_next = cfg_data;
                sdp_pkg::CFG_MAX_DEPTH: max_depth_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_depth_reg <= sdp_pkg::MIN_DEPTH_RESET;
            max_depth_reg <= sdp_pkg::MAX_DEPTH_RESET;
        end else begin
            min_depth_reg <= min_depth_next;
            max_depth_reg <= max_depth_next;
        end
    end

    always_comb begin
        in_depth             = s_tdata[15:0];
        in_side.blue         = s_tdata[23:16];
        in_side.green        = s_tdata[31:24];
        in_side.red          = s_tdata[39:32];
        in_side.point_valid  = (in_depth > min_depth_reg) && (in_depth < max_depth_reg);
    end

    sdp_pixel_counter #(
        .IMAGE_COLS (IMAGE_COLS),
        .IMAGE_ROWS (IMAGE_ROWS)
    ) u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .frame_start (s_tuser),
        .theta_addr  (theta_addr),
        .phi_addr    (phi_addr)
    );

    sdp_trig_rom #(
        .IMAGE_COLS     (IMAGE_COLS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rom (
        .aclk       (aclk),
        .rd_en      (advance),
        .theta_addr (theta_addr),
        .phi_addr   (phi_addr),
        .sin_theta  (sin_theta),
        .cos_theta  (cos_theta),
        .sin_phi    (sin_phi),
        .cos_phi    (cos_phi)
    );

    sdp_project #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .depth_mm  (in_depth),
        .side      (in_side),
        .sin_theta (sin_theta),
        .cos_theta (cos_theta),
        .sin_phi   (sin_phi),
        .cos_phi   (cos_phi),
        .out_valid (m_tvalid),
        .x_mm      (x_mm),
        .y_mm      (y_mm),
        .z_mm      (z_mm),
        .out_side  (out_side)
    );

    assign m_tdata = {5'd0, out_side.blue, out_side.green, out_side.red,
                      z_mm, y_mm, x_mm};
    assign m_tuser = out_side.point_valid;

    `SDP_ASSERT_IMPL(a_stall_holds_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `SDP_ASSERT_IMPL(a_missing_point_zero, aclk, aresetn, m_tvalid && !m_tuser, x_mm == '0 && y_mm == '0 && z_mm == '0, "missing point has coordinates")
    `SDP_ASSERT_NEXT(a_min_limit_write, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == sdp_pkg::CFG_MIN_DEPTH, min_depth_reg == $past(cfg_data), "lower limit write lost")

endmodule

FILE: hdl/sdp_pixel_counter.sv
// Column and row position tracking with sine/cosine table address generation
`include "spherical_depth_to_points_unit_macros.svh"

module sdp_pixel_counter #(
    parameter int IMAGE_COLS = 2048,
    parameter int IMAGE_ROWS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          frame_start,
    output logic [$clog2(IMAGE_COLS)-1:0] theta_addr,
    output logic [$clog2(IMAGE_COLS)-1:0] phi_addr
);

    localparam int COL_W     = $clog2(IMAGE_COLS);
    localparam int ROW_W     = (IMAGE_ROWS > 1) ? $clog2(IMAGE_ROWS) : 1;
    localparam int START     = (IMAGE_COLS - IMAGE_ROWS) / 2;
    localparam int START_MOD = ((START % IMAGE_COLS) + IMAGE_COLS) % IMAGE_COLS;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(IMAGE_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(IMAGE_ROWS - 1);
    localparam logic [COL_W-1:0] PHI_START = COL_W'(START_MOD);

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [COL_W-1:0] phi_reg, phi_next, phi_cur;

    always_comb begin
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        phi_cur = frame_start ? PHI_START : phi_reg;
    end

    assign theta_addr = col_cur;
    assign phi_addr   = phi_cur;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        phi_next = phi_reg;
        if (step) begin
            row_next = row_cur;
            phi_next = phi_cur;
            if (col_cur == COL_LAST) begin
                col_next = '0;
                if (row_cur == ROW_LAST) begin
                    row_next = '0;
                    phi_next = PHI_START;
                end else begin
                    row_next = row_cur + 1'b1;
                    phi_next = (phi_cur == COL_LAST) ? '0 : phi_cur + 1'b1;
                end
            end else begin
                col_next = col_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            phi_reg <= PHI_START;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            phi_reg <= phi_next;
        end
    end

    `SDP_ASSERT_IMPL(a_col_range, aclk, aresetn, 1'b1, col_reg <= COL_LAST, "column out of range")
    `SDP_ASSERT_IMPL(a_row_range, aclk, aresetn, 1'b1, row_reg <= ROW_LAST, "row out of range")
    `SDP_ASSERT_NEXT(a_phi_wrap, aclk, aresetn, step && col_cur == COL_LAST && row_cur == ROW_LAST, phi_reg == PHI_START && col_reg == '0, "frame wrap lost")

endmodule

FILE: hdl/sdp_trig_rom.sv
// Sine and cosine lookup memory built at elaboration, two registered read ports
module sdp_trig_rom #(
    parameter int IMAGE_COLS     = 2048,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                 aclk,
    input  logic                                 rd_en,
    input  logic [$clog2(IMAGE_COLS)-1:0]        theta_addr,
    input  logic [$clog2(IMAGE_COLS)-1:0]        phi_addr,
    output logic signed [TRIG_FRAC_BITS:0]       sin_theta,
    output logic signed [TRIG_FRAC_BITS:0]       cos_theta,
    output logic signed [TRIG_FRAC_BITS:0]       sin_phi,
    output logic signed [TRIG_FRAC_BITS:0]       cos_phi
);

    localparam int TW = TRIG_FRAC_BITS + 1;
    localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C234;
    localparam logic [63:0] ONE_Q62   = 64'h4000000000000000;
    localparam logic [63:0] PQ        = PI_Q62 / 64'(IMAGE_COLS);
    localparam logic [63:0] PR        = PI_Q62 % 64'(IMAGE_COLS);
    localparam longint      HALF_COLS = longint'(IMAGE_COLS / 2);

    typedef logic signed [TW-1:0] trig_tab_t [IMAGE_COLS];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] series(input logic [63:0] a, input logic cos_sel);
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] dv;
        a2  = mul_q62(a, a);
        t   = cos_sel ? ONE_Q62 : a;
        sum = t;
        for (int n = 1; n < 40; n++) begin
            if (t != 64'd0) begin
                dv  = cos_sel ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
                t   = udiv64(mul_q62(t, a2), dv);
                sum = n[0] ? sum - t : sum + t;
            end
        end
        return sum;
    endfunction

    function automatic logic signed [TW-1:0] quantize(input logic [63:0] v, input logic neg);
        logic [63:0] q;
        logic [63:0] top;
        q   = (v + (64'd1 << (61 - TRIG_FRAC_BITS))) >> (62 - TRIG_FRAC_BITS);
        top = (64'd1 << TRIG_FRAC_BITS) - 64'd1;
        if (q > top) begin
            q = top;
        end
        return neg ? -$signed(TW'(q)) : $signed(TW'(q));
    endfunction

    function automatic trig_tab_t build_tab(input logic cos_sel);
        trig_tab_t   tab;
        longint      m;
        logic        sneg;
        logic        cneg;
        logic [63:0] a;
        for (int k = 0; k < IMAGE_COLS; k++) begin
            m    = 2 * longint'(k) - 2 * HALF_COLS + 1;
            sneg = 1'b0;
            cneg = 1'b0;
            if (m < 0) begin
                m = m + 2 * longint'(IMAGE_COLS);
            end
            if (m >= longint'(IMAGE_COLS)) begin
                m    = m - longint'(IMAGE_COLS);
                sneg = !sneg;
                cneg = !cneg;
            end
            if (2 * m > longint'(IMAGE_COLS)) begin
                m    = longint'(IMAGE_COLS) - m;
                cneg = !cneg;
            end
            a = PQ * 64'(m) + udiv64(PR * 64'(m), 64'(IMAGE_COLS));
            tab[k] = cos_sel ? quantize(series(a, 1'b1), cneg) : quantize(series(a, 1'b0), sneg);
        end
        return tab;
    endfunction

    localparam trig_tab_t SIN_TAB = build_tab(1'b0);
    localparam trig_tab_t COS_TAB = build_tab(1'b1);

    logic signed [TW-1:0] sin_theta_reg, cos_theta_reg, sin_phi_reg, cos_phi_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            sin_theta_reg <= SIN_TAB[theta_addr];
            cos_theta_reg <= COS_TAB[theta_addr];
            sin_phi_reg   <= SIN_TAB[phi_addr];
            cos_phi_reg   <= COS_TAB[phi_addr];
        end
    end

    assign sin_theta = sin_theta_reg;
    assign cos_theta = cos_theta_reg;
    assign sin_phi   = sin_phi_reg;
    assign cos_phi   = cos_phi_reg;

endmodule

FILE: hdl/sdp_project.sv
// Projection pipeline: depth times trig products, rounding and sign
module sdp_project #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  advance,
    input  logic                                  in_valid,
    input  logic [sdp_pkg::DEPTH_W-1:0]           depth_mm,
    input  sdp_pkg::pix_side_t                    side,
    input  logic signed [TRIG_FRAC_BITS:0]        sin_theta,
    input  logic signed [TRIG_FRAC_BITS:0]        cos_theta,
    input  logic signed [TRIG_FRAC_BITS:0]        sin_phi,
    input  logic signed [TRIG_FRAC_BITS:0]        cos_phi,
    output logic                                  out_valid,
    output logic signed [sdp_pkg::COORD_W-1:0]    x_mm,
    output logic signed [sdp_pkg::COORD_W-1:0]    y_mm,
    output logic signed [sdp_pkg::COORD_W-1:0]    z_mm,
    output sdp_pkg::pix_side_t                    out_side
);

    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int DW = sdp_pkg::DEPTH_W;
    localparam int CW = sdp_pkg::COORD_W;
    localparam int PW = DW + F;
    localparam int XW = DW + 2 * F;

    function automatic logic [F-1:0] mag(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] n;
        n = -v;
        return v[TW-1] ? n[F-1:0] : v[F-1:0];
    endfunction

    function automatic logic signed [CW-1:0] signed_mm(input logic [DW-1:0] m, input logic neg);
        logic signed [CW-1:0] s;
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    logic [DW-1:0]      d1_reg;
    sdp_pkg::pix_side_t side1_reg, side2_reg, side3_reg, side4_reg;

    logic [PW-1:0] px2_reg, py2_reg;
    logic [F-1:0]  mst2_reg, mct2_reg;
    logic          sx2_reg, sy2_reg, sz2_reg;

    logic [XW-1:0] px3_reg, pz3_reg;
    logic [PW-1:0] py3_reg;
    logic          sx3_reg, sy3_reg, sz3_reg;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;

    logic [XW:0]   x_sum, z_sum;
    logic [PW:0]   y_sum;

    always_comb begin
        x_sum = (XW+1)'(px3_reg) + ((XW+1)'(1) << (2 * F - 1));
        z_sum = (XW+1)'(pz3_reg) + ((XW+1)'(1) << (2 * F - 1));
        y_sum = (PW+1)'(py3_reg) + ((PW+1)'(1) << (F - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d1_reg    <= depth_mm;
            side1_reg <= side;

            px2_reg   <= PW'(d1_reg) * PW'(mag(cos_phi));
            py2_reg   <= PW'(d1_reg) * PW'(mag(sin_phi));
            mst2_reg  <= mag(sin_theta);
            mct2_reg  <= mag(cos_theta);
            sx2_reg   <= cos_phi[TW-1] ^ sin_theta[TW-1];
            sz2_reg   <= cos_phi[TW-1] ^ cos_theta[TW-1];
            sy2_reg   <= sin_phi[TW-1];
            side2_reg <= side1_reg;

            px3_reg   <= XW'(px2_reg) * XW'(mst2_reg);
            pz3_reg   <= XW'(px2_reg) * XW'(mct2_reg);
            py3_reg   <= py2_reg;
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            sz3_reg   <= sz2_reg;
            side3_reg <= side2_reg;

            x_reg     <= side3_reg.point_valid ? signed_mm(x_sum[2*F+DW-1:2*F], sx3_reg) : '0;
            z_reg     <= side3_reg.point_valid ? signed_mm(z_sum[2*F+DW-1:2*F], sz3_reg) : '0;
            y_reg     <= side3_reg.point_valid ? signed_mm(y_sum[F+DW-1:F], sy3_reg) : '0;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign x_mm      = x_reg;
    assign y_mm      = y_reg;
    assign z_mm      = z_reg;
    assign out_side  = side4_reg;

endmodule

FILE: sim/testbench.sv
// Testbench for the spherical depth to point cloud converter: stream stimulus and point checking
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_W        = sdp_pkg::DEPTH_W;
    localparam int COLOUR_W       = sdp_pkg::COLOUR_W;
    localparam int COORD_W        = sdp_pkg::COORD_W;
    localparam int S_TDATA_W      = sdp_pkg::S_TDATA_W;
    localparam int M_TDATA_W      = sdp_pkg::M_TDATA_W;
    localparam int CFG_INDEX_W    = sdp_pkg::CFG_INDEX_W;
    localparam int IMAGE_COLS     = 2048;
    localparam int IMAGE_ROWS     = 1024;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam bit [63:0] PI_Q62  = 64'hC90FDAA22168C234;
    localparam bit [63:0] ONE_Q62 = 64'd1 << 62;

    typedef struct {
        bit [DEPTH_W-1:0]  depth;
        bit [COLOUR_W-1:0] blue;
        bit [COLOUR_W-1:0] green;
        bit [COLOUR_W-1:0] red;
        bit                frame_start;
    } pixel_t;

    typedef struct {
        bit [COORD_W-1:0]  x;
        bit [COORD_W-1:0]  y;
        bit [COORD_W-1:0]  z;
        bit [COLOUR_W-1:0] red;
        bit [COLOUR_W-1:0] green;
        bit [COLOUR_W-1:0] blue;
        bit                valid;
    } point_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DEPTH_W-1:0]     cfg_data = '0;

    int sin_tab [IMAGE_COLS];
    int cos_tab [IMAGE_COLS];

    bit [DEPTH_W-1:0] min_limit = sdp_pkg::MIN_DEPTH_RESET;
    bit [DEPTH_W-1:0] max_limit = sdp_pkg::MAX_DEPTH_RESET;
    int col_pos = 0;
    int row_pos = 0;
    int furthest_row = 0;

    pixel_t pixel_queue [$];
    point_t point_queue [$];
    pixel_t offered_pixel;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  narrow_focus = 1'b0;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  error_count = 0;
    int  pixels_sent = 0;
    int  points_seen = 0;
    int  valid_seen = 0;
    int  settings_count = 0;
    int  cycle_count = 0;

    spherical_depth_to_points_unit #(
        .IMAGE_COLS     (IMAGE_COLS),
        .IMAGE_ROWS     (IMAGE_ROWS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
        bit [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    function automatic int trig_round(bit [63:0] v, bit neg);
        bit [63:0] q;
        q = (v + (64'd1 << (61 - TRIG_FRAC_BITS))) >> (62 - TRIG_FRAC_BITS);
        if (q > (64'd1 << TRIG_FRAC_BITS) - 1)
            q = (64'd1 << TRIG_FRAC_BITS) - 1;
        return neg ? -int'(q) : int'(q);
    endfunction

    // d * p * q / 2^(2F), magnitude rounded half away from zero
    function automatic bit [COORD_W-1:0] scale_mm(bit [DEPTH_W-1:0] d, int p, int q);
        longint unsigned mag;
        longint          r;
        mag = longint'(d) * longint'(p < 0 ? -p : p) * longint'(q < 0 ? -q : q);
        r = longint'((mag + (64'd1 << (2 * TRIG_FRAC_BITS - 1))) >> (2 * TRIG_FRAC_BITS));
        if ((p < 0) != (q < 0))
            r = -r;
        return r[COORD_W-1:0];
    endfunction

    initial begin : trig_table_build
        longint    m;
        bit [63:0] pq, pr, ang, a2, t, s_sum, c_sum, nn;
        bit        sneg, cneg;
        pq = PI_Q62 / IMAGE_COLS;
        pr = PI_Q62 % IMAGE_COLS;
        for (int k = 0; k < IMAGE_COLS; k++) begin
            m = 2 * k - 2 * (IMAGE_COLS / 2) + 1;
            sneg = 1'b0;
            cneg = 1'b0;
            if (m < 0)
                m += 2 * IMAGE_COLS;
            if (m >= IMAGE_COLS) begin
                m -= IMAGE_COLS;
                sneg = ~sneg;
                cneg = ~cneg;
            end
            if (2 * m > IMAGE_COLS) begin
                m = IMAGE_COLS - m;
                cneg = ~cneg;
            end
            ang = pq * 64'(m) + (pr * 64'(m)) / IMAGE_COLS;
            a2 = q62_mul(ang, ang);
            t = ang;
            s_sum = ang;
            for (nn = 1; nn < 40 && t != 0; nn++) begin
                t = q62_mul(t, a2) / ((2 * nn) * (2 * nn + 1));
                s_sum = nn[0] ? s_sum - t : s_sum + t;
            end
            t = ONE_Q62;
            c_sum = ONE_Q62;
            for (nn = 1; nn < 40 && t != 0; nn++) begin
                t = q62_mul(t, a2) / ((2 * nn - 1) * (2 * nn));
                c_sum = nn[0] ? c_sum - t : c_sum + t;
            end
            sin_tab[k] = trig_round(s_sum, sneg);
            cos_tab[k] = trig_round(c_sum, cneg);
        end
    end

    // expected point for one accepted pixel; advances the position counters
    function automatic point_t project_pixel(pixel_t px);
        point_t pt;
        int     tidx, pidx;
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        tidx = col_pos % IMAGE_COLS;
        pidx = ((IMAGE_COLS - IMAGE_ROWS) / 2 + row_pos) % IMAGE_COLS;
        if (pidx < 0)
            pidx += IMAGE_COLS;
        pt.valid = (px.depth > min_limit) && (px.depth < max_limit);
        pt.x = '0;
        pt.y = '0;
        pt.z = '0;
        if (pt.valid) begin
            pt.x = scale_mm(px.depth, cos_tab[pidx], sin_tab[tidx]);
            pt.y = scale_mm(px.depth, sin_tab[pidx], 1 << TRIG_FRAC_BITS);
            pt.z = scale_mm(px.depth, cos_tab[pidx], cos_tab[tidx]);
        end
        pt.red = px.red;
        pt.green = px.green;
        pt.blue = px.blue;
        col_pos = tidx + 1;
        if (col_pos >= IMAGE_COLS) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= IMAGE_ROWS)
                row_pos = 0;
            if (row_pos > furthest_row)
                furthest_row = row_pos;
        end
        return pt;
    endfunction

    function automatic bit [DEPTH_W-1:0] pick_depth();
        bit [DEPTH_W-1:0] d;
        d = DEPTH_W'($urandom_range(0, 65535));
        if (narrow_focus && $urandom_range(0, 1) == 1)
            d = min_limit + 1'b1;
        else if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
                0: d = '0;
                1: d = '1;
                2: d = min_limit;
                3: d = min_limit + 1'b1;
                4: d = max_limit - 1'b1;
                default: d = max_limit;
            endcase
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR at cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic write_register(bit [CFG_INDEX_W-1:0] idx, bit [DEPTH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        if (idx == sdp_pkg::CFG_MIN_DEPTH)
            min_limit = value;
        else if (idx == sdp_pkg::CFG_MAX_DEPTH)
            max_limit = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic fill_phase(int count, int s_idle, int r_stall, int fs_odds);
        pixel_t px;
        send_idle_pct = s_idle;
        stall_pct = r_stall;
        settings_count++;
        for (int i = 0; i < count; i++) begin
            px.depth = pick_depth();
            px.blue = COLOUR_W'($urandom);
            px.green = COLOUR_W'($urandom);
            px.red = COLOUR_W'($urandom);
            px.frame_start = (fs_odds != 0) && ($urandom_range(1, fs_odds) == 1);
            pixel_queue.push_back(px);
        end
    endtask

    task automatic drain_points();
        @(negedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || point_queue.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : pixel_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                point_queue.push_back(project_pixel(offered_pixel));
                pixels_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered_pixel = pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {offered_pixel.red, offered_pixel.green,
                                offered_pixel.blue, offered_pixel.depth};
                    s_tuser <= offered_pixel.frame_start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    always @(posedge aclk) begin : hold_counter
        if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : point_monitor
        point_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                points_seen++;
                if (m_tuser)
                    valid_seen++;
                if (point_queue.size() == 0) begin
                    report_mismatch("point with no pixel pending", points_seen, 0);
                end else begin
                    want = point_queue.pop_front();
                    if (m_tdata[16:0] != want.x)
                        report_mismatch("x_mm", $signed(m_tdata[16:0]), $signed(want.x));
                    if (m_tdata[33:17] != want.y)
                        report_mismatch("y_mm", $signed(m_tdata[33:17]), $signed(want.y));
                    if (m_tdata[50:34] != want.z)
                        report_mismatch("z_mm", $signed(m_tdata[50:34]), $signed(want.z));
                    if (m_tdata[58:51] != want.red)
                        report_mismatch("red_out", m_tdata[58:51], want.red);
                    if (m_tdata[66:59] != want.green)
                        report_mismatch("green_out", m_tdata[66:59], want.green);
                    if (m_tdata[74:67] != want.blue)
                        report_mismatch("blue_out", m_tdata[74:67], want.blue);
                    if (m_tuser != want.valid)
                        report_mismatch("point_valid", m_tuser, want.valid);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("spherical_depth_to_points_unit verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        bit [DEPTH_W-1:0] directed_depth [16] = '{16'd0, 16'd65535, 16'd400, 16'd401,
                                                 16'd19999, 16'd20000, 16'd12345, 16'd1000,
                                                 16'd5000, 16'd5000, 16'd5000, 16'd5000,
                                                 16'd19999, 16'd401, 16'd8191, 16'd32768};
        pixel_t           px;
        bit [DEPTH_W-1:0] low_edge;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: depth extremes, limit edges, frame restart mid-row
        for (int i = 0; i < 16; i++) begin
            px.depth = directed_depth[i];
            px.blue = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : COLOUR_W'($urandom);
            px.green = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : COLOUR_W'($urandom);
            px.red = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : COLOUR_W'($urandom);
            px.frame_start = (i == 0) || (i == 7) || (i == 12);
            pixel_queue.push_back(px);
        end
        settings_count++;
        drain_points();

        // widest window, no frame restarts
        write_register(sdp_pkg::CFG_MIN_DEPTH, 16'd0);
        write_register(sdp_pkg::CFG_MAX_DEPTH, 16'hFFFF);
        fill_phase(650, 0, 0, 0);
        @(negedge aclk);
        hold_go = 1'b1;
        drain_points();

        write_register(sdp_pkg::CFG_MIN_DEPTH, DEPTH_W'($urandom_range(0, 3000)));
        write_register(sdp_pkg::CFG_MAX_DEPTH, DEPTH_W'($urandom_range(10000, 65535)));
        fill_phase(650, 59, 0, 0);
        drain_points();

        // inverted limits: nothing valid
        write_register(sdp_pkg::CFG_MIN_DEPTH, 16'hFFFF);
        write_register(sdp_pkg::CFG_MAX_DEPTH, 16'd0);
        fill_phase(130, 0, 59, 64);
        drain_points();

        // one-value window
        low_edge = DEPTH_W'($urandom_range(0, 1000));
        write_register(sdp_pkg::CFG_MIN_DEPTH, low_edge);
        write_register(sdp_pkg::CFG_MAX_DEPTH, low_edge + 16'd2);
        narrow_focus = 1'b1;
        fill_phase(200, 22, 22, 32);
        drain_points();

        if (point_queue.size() != 0)
            report_mismatch("points never delivered", point_queue.size(), 0);
        $display("Run covered %0d pixels and %0d points (%0d valid) over %0d limit settings,",
                 pixels_sent, points_seen, valid_seen, settings_count);
        $display("reaching image row %0d; %0d mismatches.", furthest_row, error_count);
        if (error_count == 0) begin
            $display("spherical_depth_to_points_unit verification clean");
        end else begin
            $display("spherical_depth_to_points_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/sdp_pkg.sv
hdl/sdp_pixel_counter.sv
hdl/sdp_trig_rom.sv
hdl/sdp_project.sv
hdl/spherical_depth_to_points_unit.sv
sim/testbench.sv
